>>> rtl/core/cvfm_pkg.sv
// cvfm_pkg: shared types and constants of the cell voltage fault monitor
// no dependencies; imported by every module of the block except cvfm_ram
`default_nettype none

package cvfm_pkg;

  localparam int unsigned DEF_MODULES = 8;
  localparam int unsigned DEF_CELLS   = 16;

  localparam int unsigned MOD_W      = 3;
  localparam int unsigned CELL_W     = 4;
  localparam int unsigned VOLT_W     = 16;
  localparam int unsigned TIME_W     = 32;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 32;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_OVER_WARN     = 3'd0,
    CFG_OVER_FAULT    = 3'd1,
    CFG_OVER_MARGIN   = 3'd2,
    CFG_OVER_DELAY    = 3'd3,
    CFG_UNDER_WARN    = 3'd4,
    CFG_UNDER_FAULT   = 3'd5,
    CFG_UNDER_MARGIN  = 3'd6,
    CFG_UNDER_DELAY   = 3'd7
  } cfg_idx_e;

  typedef struct packed {
    logic [VOLT_W-1:0] over_warn;
    logic [VOLT_W-1:0] over_fault;
    logic [VOLT_W-1:0] over_margin;
    logic [TIME_W-1:0] over_delay;
    logic [VOLT_W-1:0] under_warn;
    logic [VOLT_W-1:0] under_fault;
    logic [VOLT_W-1:0] under_margin;
    logic [TIME_W-1:0] under_delay;
  } cfg_t;

  // per-cell record kept in the state memory
  typedef struct packed {
    logic              over_lat;
    logic              under_lat;
    logic [TIME_W-1:0] over_start;
    logic [TIME_W-1:0] under_start;
  } cell_rec_t;

  // outcome of one fault channel update
  typedef struct packed {
    logic [TIME_W-1:0] start;
    logic              flag;
    logic              latch;
    logic              release_ev;
  } chan_res_t;

endpackage

`default_nettype wire

>>> rtl/core/cvfm_ram.sv
// cvfm_ram: generic single-write, single-read RAM with registered read data
// no package dependencies
`default_nettype none

module cvfm_ram #(
  parameter int unsigned WIDTH = 66,
  parameter int unsigned DEPTH = 128,
  localparam int unsigned AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AW-1:0]    waddr_i,
  input  wire logic [WIDTH-1:0] wdata_i,
  input  wire logic             re_i,
  input  wire logic [AW-1:0]    raddr_i,
  output logic      [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

>>> rtl/core/cvfm_cfg.sv
// cvfm_cfg: threshold, margin and delay registers with their reset values
// depends on cvfm_pkg
`default_nettype none

module cvfm_cfg (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  input  wire logic                                we_i,
  input  wire logic [cvfm_pkg::CFG_IDX_W-1:0]      index_i,
  input  wire logic [cvfm_pkg::CFG_DATA_W-1:0]     wdata_i,
  output cvfm_pkg::cfg_t                           cfg_o
);

  import cvfm_pkg::*;

  cfg_t cfg_q, cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (we_i) begin
      case (cfg_idx_e'(index_i))
        CFG_OVER_WARN:    cfg_d.over_warn    = wdata_i[VOLT_W-1:0];
        CFG_OVER_FAULT:   cfg_d.over_fault   = wdata_i[VOLT_W-1:0];
        CFG_OVER_MARGIN:  cfg_d.over_margin  = wdata_i[VOLT_W-1:0];
        CFG_OVER_DELAY:   cfg_d.over_delay   = wdata_i[TIME_W-1:0];
        CFG_UNDER_WARN:   cfg_d.under_warn   = wdata_i[VOLT_W-1:0];
        CFG_UNDER_FAULT:  cfg_d.under_fault  = wdata_i[VOLT_W-1:0];
        CFG_UNDER_MARGIN: cfg_d.under_margin = wdata_i[VOLT_W-1:0];
        CFG_UNDER_DELAY:  cfg_d.under_delay  = wdata_i[TIME_W-1:0];
        default:          cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.over_warn    <= '1;
      cfg_q.over_fault   <= '1;
      cfg_q.over_margin  <= '0;
      cfg_q.over_delay   <= '0;
      cfg_q.under_warn   <= '0;
      cfg_q.under_fault  <= '0;
      cfg_q.under_margin <= '0;
      cfg_q.under_delay  <= '0;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

`default_nettype wire

>>> rtl/core/cvfm_chan.sv
// cvfm_chan: one fault channel (timer start, latch and release) of one cell
// depends on cvfm_pkg
`default_nettype none

module cvfm_chan (
  input  wire logic                           cond_i,
  input  wire logic                           rel_i,
  input  wire logic [cvfm_pkg::TIME_W-1:0]    start_i,
  input  wire logic                           flag_i,
  input  wire logic [cvfm_pkg::TIME_W-1:0]    now_i,
  input  wire logic [cvfm_pkg::TIME_W-1:0]    delay_i,
  output cvfm_pkg::chan_res_t                 res_o
);

  import cvfm_pkg::*;

  logic [TIME_W-1:0] elapsed;

  // modulo 2^32 elapsed time
  assign elapsed = now_i - start_i;

  always_comb begin
    res_o.start      = start_i;
    res_o.flag       = flag_i;
    res_o.latch      = 1'b0;
    res_o.release_ev = 1'b0;
    if (cond_i) begin
      if (start_i == '0) begin
        res_o.start = now_i;
      end else if (elapsed > delay_i && !flag_i) begin
        res_o.flag  = 1'b1;
        res_o.latch = 1'b1;
      end
    end else begin
      res_o.start = '0;
      if (rel_i && flag_i) begin
        res_o.flag       = 1'b0;
        res_o.release_ev = 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

>>> rtl/core/cell_voltage_fault_monitor.sv
// cell_voltage_fault_monitor: top level, per-cell state memory with
// read-modify-write, forwarding, fault count and shutdown line
// depends on cvfm_pkg, cvfm_ram, cvfm_cfg, cvfm_chan
`default_nettype none

// channel    handshake                  payload
// ---------  -------------------------  --------------------------------------------
// sample in  in_valid_i / in_ready_o    module_index_i, cell_index_i, cell_voltage_i,
//                                       now_ms_i
// result out out_valid_o / out_ready_i  out_module_o, out_cell_o, over_warning_o,
//                                       under_warning_o, over_fault_o, under_fault_o,
//                                       shutdown_active_o
// config     cfg_we_i (no handshake)    cfg_index_i, cfg_wdata_i
//
// one sample per cycle sustained while results are taken; the result register loads
// after the evaluate stage: the state memory read loads at the sample transfer, then
// update, write-back and the result register load happen at the same edge
// reset needs no clearing pass: one valid bit per cell, an entry not yet written
// reads as all zero
// a stalled result holds the evaluate stage, which then holds the input side

module cell_voltage_fault_monitor #(
  parameter int unsigned MODULES          = cvfm_pkg::DEF_MODULES,
  parameter int unsigned CELLS_PER_MODULE = cvfm_pkg::DEF_CELLS
) (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  // configuration writes
  input  wire logic                             cfg_we_i,
  input  wire logic [cvfm_pkg::CFG_IDX_W-1:0]   cfg_index_i,
  input  wire logic [cvfm_pkg::CFG_DATA_W-1:0]  cfg_wdata_i,
  // sample input
  input  wire logic                             in_valid_i,
  output logic                                  in_ready_o,
  input  wire logic [cvfm_pkg::MOD_W-1:0]       module_index_i,
  input  wire logic [cvfm_pkg::CELL_W-1:0]      cell_index_i,
  input  wire logic [cvfm_pkg::VOLT_W-1:0]      cell_voltage_i,
  input  wire logic [cvfm_pkg::TIME_W-1:0]      now_ms_i,
  // result output
  output logic                                  out_valid_o,
  input  wire logic                             out_ready_i,
  output logic      [cvfm_pkg::MOD_W-1:0]       out_module_o,
  output logic      [cvfm_pkg::CELL_W-1:0]      out_cell_o,
  output logic                                  over_warning_o,
  output logic                                  under_warning_o,
  output logic                                  over_fault_o,
  output logic                                  under_fault_o,
  output logic                                  shutdown_active_o
);

  import cvfm_pkg::*;

  localparam int unsigned NCELLS  = MODULES * CELLS_PER_MODULE;
  localparam int unsigned SLOT_W  = (NCELLS > 1) ? $clog2(NCELLS) : 1;
  localparam int unsigned CNT_W   = $clog2(2 * NCELLS + 1);
  localparam int unsigned SLOT_WW = MOD_W + CELL_W + 1;
  localparam int unsigned REC_W   = $bits(cell_rec_t);

  cfg_t cfg;

  cvfm_cfg u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .we_i    (cfg_we_i),
    .index_i (cfg_index_i),
    .wdata_i (cfg_wdata_i),
    .cfg_o   (cfg)
  );

  // ---------------------------------------------------------------------------
  // handshake and stage control
  // ---------------------------------------------------------------------------
  logic s1_valid_q;
  logic out_valid_q;
  logic out_free;
  logic s1_fire;
  logic in_xfer;

  assign out_free   = !out_valid_q || out_ready_i;
  assign s1_fire    = s1_valid_q && out_free;
  assign in_ready_o = !s1_valid_q || out_free;
  assign in_xfer    = in_valid_i && in_ready_o;

  // ---------------------------------------------------------------------------
  // read issue: slot index and range check
  // ---------------------------------------------------------------------------
  logic [SLOT_WW-1:0] slot_wide;
  logic [SLOT_W-1:0]  rd_slot;
  logic               in_range;

  assign slot_wide = SLOT_WW'(module_index_i) * SLOT_WW'(CELLS_PER_MODULE)
                   + SLOT_WW'(cell_index_i);
  assign rd_slot   = slot_wide[SLOT_W-1:0];
  assign in_range  = (32'(module_index_i) < 32'(MODULES))
                  && (32'(cell_index_i) < 32'(CELLS_PER_MODULE));

  // ---------------------------------------------------------------------------
  // evaluate stage registers (memory data returns here)
  // ---------------------------------------------------------------------------
  logic [MOD_W-1:0]  s1_mod_q;
  logic [CELL_W-1:0] s1_cell_q;
  logic [VOLT_W-1:0] s1_volt_q;
  logic [TIME_W-1:0] s1_now_q;
  logic [SLOT_W-1:0] s1_slot_q;
  logic              s1_inrng_q;
  logic              s1_vld_q;

  // one valid bit per cell; an entry never written reads as zero
  logic [NCELLS-1:0] vld_q;

  // last write-back, forwarded to a read that overlapped it
  logic              fwd_vld_q;
  logic [SLOT_W-1:0] fwd_slot_q;
  cell_rec_t         fwd_rec_q;

  logic              wr_en;
  cell_rec_t         wr_rec;
  logic [REC_W-1:0]  rd_data;
  cell_rec_t         cur_rec;

  cvfm_ram #(
    .WIDTH (REC_W),
    .DEPTH (NCELLS)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (wr_en),
    .waddr_i (s1_slot_q),
    .wdata_i (wr_rec),
    .re_i    (in_xfer),
    .raddr_i (rd_slot),
    .rdata_o (rd_data)
  );

  // forwarding picks the newest copy of this cell's record
  always_comb begin
    if (fwd_vld_q && fwd_slot_q == s1_slot_q) begin
      cur_rec = fwd_rec_q;
    end else if (s1_vld_q) begin
      cur_rec = cell_rec_t'(rd_data);
    end else begin
      cur_rec = '0;
    end
  end

  // ---------------------------------------------------------------------------
  // compares and fault channels
  // ---------------------------------------------------------------------------
  logic over_cond, over_rel, under_cond, under_rel;
  logic over_warn, under_warn;

  assign over_warn  = s1_volt_q >= cfg.over_warn;
  assign under_warn = s1_volt_q <= cfg.under_warn;
  assign over_cond  = s1_volt_q >= cfg.over_fault;
  assign under_cond = s1_volt_q <= cfg.under_fault;
  // release bounds without wrap: v < level - margin, v > level + margin
  assign over_rel   = ({1'b0, s1_volt_q} + {1'b0, cfg.over_margin}) < {1'b0, cfg.over_fault};
  assign under_rel  = {1'b0, s1_volt_q} > ({1'b0, cfg.under_fault} + {1'b0, cfg.under_margin});

  chan_res_t ov_res, un_res;

  cvfm_chan u_over (
    .cond_i  (over_cond),
    .rel_i   (over_rel),
    .start_i (cur_rec.over_start),
    .flag_i  (cur_rec.over_lat),
    .now_i   (s1_now_q),
    .delay_i (cfg.over_delay),
    .res_o   (ov_res)
  );

  cvfm_chan u_under (
    .cond_i  (under_cond),
    .rel_i   (under_rel),
    .start_i (cur_rec.under_start),
    .flag_i  (cur_rec.under_lat),
    .now_i   (s1_now_q),
    .delay_i (cfg.under_delay),
    .res_o   (un_res)
  );

  assign wr_en              = s1_fire && s1_inrng_q;
  assign wr_rec.over_lat    = ov_res.flag;
  assign wr_rec.under_lat   = un_res.flag;
  assign wr_rec.over_start  = ov_res.start;
  assign wr_rec.under_start = un_res.start;

  // ---------------------------------------------------------------------------
  // active fault count and shutdown line, over channel applied before under
  // ---------------------------------------------------------------------------
  logic [CNT_W-1:0] cnt_q, cnt_d, cnt_mid;
  logic             line_q, line_d, line_mid;

  always_comb begin
    cnt_mid  = cnt_q;
    line_mid = line_q;
    if (ov_res.latch) begin
      cnt_mid  = cnt_mid + CNT_W'(1);
      line_mid = 1'b1;
    end else if (ov_res.release_ev) begin
      if (cnt_mid != '0) begin
        cnt_mid = cnt_mid - CNT_W'(1);
      end
      if (cnt_mid == '0) begin
        line_mid = 1'b0;
      end
    end
    cnt_d  = cnt_mid;
    line_d = line_mid;
    if (un_res.latch) begin
      cnt_d  = cnt_d + CNT_W'(1);
      line_d = 1'b1;
    end else if (un_res.release_ev) begin
      if (cnt_d != '0) begin
        cnt_d = cnt_d - CNT_W'(1);
      end
      if (cnt_d == '0) begin
        line_d = 1'b0;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // control registers
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      vld_q       <= '0;
      fwd_vld_q   <= 1'b0;
      cnt_q       <= '0;
      line_q      <= 1'b0;
    end else begin
      if (in_ready_o) begin
        s1_valid_q <= in_valid_i;
      end
      if (out_free) begin
        out_valid_q <= s1_valid_q;
      end
      if (wr_en) begin
        vld_q[s1_slot_q] <= 1'b1;
        fwd_vld_q        <= 1'b1;
        cnt_q            <= cnt_d;
        line_q           <= line_d;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // payload registers
  // ---------------------------------------------------------------------------
  logic [MOD_W-1:0]  out_mod_q;
  logic [CELL_W-1:0] out_cell_q;
  logic              out_owarn_q, out_uwarn_q, out_ofault_q, out_ufault_q, out_shut_q;

  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      s1_mod_q   <= module_index_i;
      s1_cell_q  <= cell_index_i;
      s1_volt_q  <= cell_voltage_i;
      s1_now_q   <= now_ms_i;
      s1_slot_q  <= rd_slot;
      s1_inrng_q <= in_range;
      s1_vld_q   <= vld_q[rd_slot];
    end
    if (wr_en) begin
      fwd_slot_q <= s1_slot_q;
      fwd_rec_q  <= wr_rec;
    end
    if (s1_fire) begin
      out_mod_q    <= s1_mod_q;
      out_cell_q   <= s1_cell_q;
      out_owarn_q  <= over_warn;
      out_uwarn_q  <= under_warn;
      out_ofault_q <= s1_inrng_q && ov_res.flag;
      out_ufault_q <= s1_inrng_q && un_res.flag;
      out_shut_q   <= s1_inrng_q ? line_d : line_q;
    end
  end

  assign out_valid_o       = out_valid_q;
  assign out_module_o      = out_mod_q;
  assign out_cell_o        = out_cell_q;
  assign over_warning_o    = out_owarn_q;
  assign under_warning_o   = out_uwarn_q;
  assign over_fault_o      = out_ofault_q;
  assign under_fault_o     = out_ufault_q;
  assign shutdown_active_o = out_shut_q;

  // ---------------------------------------------------------------------------
  // assertions
  // ---------------------------------------------------------------------------
  // the line is high exactly while some fault is latched
  a_line_tracks_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    line_q == (cnt_q != '0))
    else $error("shutdown line disagrees with active fault count");

  // the count never passes the number of fault latches
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    32'(cnt_q) <= 2 * NCELLS)
    else $error("active fault count out of range");

  // a result reporting a latched fault must show the line asserted
  a_fault_implies_line: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && (out_ofault_q || out_ufault_q)) |-> out_shut_q)
    else $error("latched fault reported with shutdown line released");

  // a write-back always makes its entry valid for later reads
  a_write_sets_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    wr_en |=> vld_q[$past(s1_slot_q)] && fwd_vld_q)
    else $error("write-back did not mark the cell entry valid");

endmodule

`default_nettype wire

>>> verif/tb_cell_voltage_fault_monitor.sv
// tb_cell_voltage_fault_monitor: self-checking testbench of the cell voltage fault monitor
// predicts warnings, per-cell fault latches and the shutdown line for every sample
// depends on cvfm_pkg and cell_voltage_fault_monitor

module tb_cell_voltage_fault_monitor;
  import cvfm_pkg::*;

  localparam int unsigned N_MODULES   = DEF_MODULES;
  localparam int unsigned N_CELLS     = DEF_CELLS;
  localparam int unsigned N_SLOTS     = N_MODULES * N_CELLS;
  localparam int unsigned CYCLE_LIMIT = 300000;
  localparam int unsigned DRAIN_WAIT  = 4;
  localparam int unsigned RAND_PHASES = 6;
  localparam int unsigned PHASE_ITEMS = 45;

  // one result transfer as the block should present it
  typedef struct packed {
    logic [MOD_W-1:0]  mod_idx;
    logic [CELL_W-1:0] cell_idx;
    logic              over_warn;
    logic              under_warn;
    logic              over_flt;
    logic              under_flt;
    logic              shutdown;
  } verdict_t;

  logic                  clk_i;
  logic                  rst_ni;
  logic                  cfg_we_i;
  logic [CFG_IDX_W-1:0]  cfg_index_i;
  logic [CFG_DATA_W-1:0] cfg_wdata_i;
  logic                  in_valid_i;
  logic                  in_ready_o;
  logic [MOD_W-1:0]      module_index_i;
  logic [CELL_W-1:0]     cell_index_i;
  logic [VOLT_W-1:0]     cell_voltage_i;
  logic [TIME_W-1:0]     now_ms_i;
  logic                  out_valid_o;
  logic                  out_ready_i;
  logic [MOD_W-1:0]      out_module_o;
  logic [CELL_W-1:0]     out_cell_o;
  logic                  over_warning_o;
  logic                  under_warning_o;
  logic                  over_fault_o;
  logic                  under_fault_o;
  logic                  shutdown_active_o;

  cell_voltage_fault_monitor i_dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_we_i         (cfg_we_i),
    .cfg_index_i      (cfg_index_i),
    .cfg_wdata_i      (cfg_wdata_i),
    .in_valid_i       (in_valid_i),
    .in_ready_o       (in_ready_o),
    .module_index_i   (module_index_i),
    .cell_index_i     (cell_index_i),
    .cell_voltage_i   (cell_voltage_i),
    .now_ms_i         (now_ms_i),
    .out_valid_o      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .out_module_o     (out_module_o),
    .out_cell_o       (out_cell_o),
    .over_warning_o   (over_warning_o),
    .under_warning_o  (under_warning_o),
    .over_fault_o     (over_fault_o),
    .under_fault_o    (under_fault_o),
    .shutdown_active_o(shutdown_active_o)
  );

  // ---------------------------------------------------------------------------
  // shadow of the block: thresholds, per-cell timers and latches, fault count
  // ---------------------------------------------------------------------------
  cfg_t              thresholds;
  logic [TIME_W-1:0] over_start_ms  [N_SLOTS];
  logic [TIME_W-1:0] under_start_ms [N_SLOTS];
  bit                over_latched   [N_SLOTS];
  bit                under_latched  [N_SLOTS];
  int unsigned       faults_latched;
  bit                shutdown_line;

  // verdicts of accepted samples, oldest first
  verdict_t          pending_verdicts[$];
  int unsigned       mismatches;

  // traffic shaping shared by the stimulus and the result sink
  bit                src_idle;
  bit                sink_idle;
  int unsigned       hold_request;
  logic [TIME_W-1:0] clock_ms;

  function automatic void clear_shadow();
    thresholds.over_warn    = 16'hFFFF;
    thresholds.over_fault   = 16'hFFFF;
    thresholds.over_margin  = '0;
    thresholds.over_delay   = '0;
    thresholds.under_warn   = '0;
    thresholds.under_fault  = '0;
    thresholds.under_margin = '0;
    thresholds.under_delay  = '0;
    for (int s = 0; s < N_SLOTS; s++) begin
      over_start_ms[s]  = '0;
      under_start_ms[s] = '0;
      over_latched[s]   = 1'b0;
      under_latched[s]  = 1'b0;
    end
    faults_latched = 0;
    shutdown_line  = 1'b0;
  endfunction

  // one fault channel: a start time of zero means the timer is idle
  function automatic void run_timer(input bit cond, input bit released,
                                    inout logic [TIME_W-1:0] start, inout bit flag,
                                    input logic [TIME_W-1:0] now,
                                    input logic [TIME_W-1:0] delay);
    logic [TIME_W-1:0] elapsed;
    elapsed = now - start;
    if (cond) begin
      if (start == '0) begin
        start = now;
      end else if (elapsed > delay && !flag) begin
        flag           = 1'b1;
        faults_latched = faults_latched + 1;
        shutdown_line  = 1'b1;
      end
    end else begin
      start = '0;
      if (released && flag) begin
        flag = 1'b0;
        if (faults_latched > 0) faults_latched = faults_latched - 1;
        if (faults_latched == 0) shutdown_line = 1'b0;
      end
    end
  endfunction

  // evaluates one sample against the shadow state and advances it
  function automatic verdict_t judge_sample(input logic [MOD_W-1:0] m,
                                            input logic [CELL_W-1:0] c,
                                            input logic [VOLT_W-1:0] v,
                                            input logic [TIME_W-1:0] now);
    verdict_t r;
    int       volt;
    int       ofl;
    int       ufl;
    int       over_bound;
    int       under_bound;
    int       slot;
    volt          = int'(v);
    ofl           = int'(thresholds.over_fault);
    ufl           = int'(thresholds.under_fault);
    over_bound    = ofl - int'(thresholds.over_margin);
    under_bound   = ufl + int'(thresholds.under_margin);
    r.mod_idx     = m;
    r.cell_idx    = c;
    r.over_warn   = (v >= thresholds.over_warn);
    r.under_warn  = (v <= thresholds.under_warn);
    r.over_flt    = 1'b0;
    r.under_flt   = 1'b0;
    if (m < N_MODULES && c < N_CELLS) begin
      slot = m * N_CELLS + c;
      run_timer(volt >= ofl, volt < over_bound, over_start_ms[slot], over_latched[slot],
                now, thresholds.over_delay);
      run_timer(volt <= ufl, volt > under_bound, under_start_ms[slot],
                under_latched[slot], now, thresholds.under_delay);
      r.over_flt  = over_latched[slot];
      r.under_flt = under_latched[slot];
    end
    r.shutdown = shutdown_line;
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // clock, watchdog
  // ---------------------------------------------------------------------------
  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin : watchdog
    int unsigned cycles;
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycles++;
    end
    $display("FAIL");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // result side: random stalls, plus one long hold-off on request
  // ---------------------------------------------------------------------------
  initial begin : result_sink
    int unsigned stall;
    out_ready_i = 1'b0;
    wait (rst_ni === 1'b1);
    forever begin
      stall = sink_idle ? $urandom_range(0, 16) : 0;
      if (hold_request != 0) begin
        stall        = hold_request;
        hold_request = 0;
      end
      @(negedge clk_i);
      if (stall != 0) begin
        out_ready_i <= 1'b0;
        repeat (stall) @(negedge clk_i);
      end
      out_ready_i <= 1'b1;
      // ready stays up until the next result transfer
      do @(posedge clk_i); while (!out_valid_o);
    end
  end

  function automatic void check_field(input string name, input logic [31:0] want,
                                      input logic [31:0] got);
    if (want !== got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      mismatches++;
    end
  endfunction

  // every result transfer is matched against the oldest pending verdict
  initial begin : result_check
    verdict_t want;
    forever begin
      @(posedge clk_i);
      if (rst_ni && out_valid_o && out_ready_i) begin
        if (pending_verdicts.size() == 0) begin
          $error("result transfer with no sample pending");
          mismatches++;
        end else begin
          want = pending_verdicts.pop_front();
          check_field("out_module", 32'(want.mod_idx), 32'(out_module_o));
          check_field("out_cell", 32'(want.cell_idx), 32'(out_cell_o));
          check_field("over_warning", 32'(want.over_warn), 32'(over_warning_o));
          check_field("under_warning", 32'(want.under_warn), 32'(under_warning_o));
          check_field("over_fault", 32'(want.over_flt), 32'(over_fault_o));
          check_field("under_fault", 32'(want.under_flt), 32'(under_fault_o));
          check_field("shutdown_active", 32'(want.shutdown), 32'(shutdown_active_o));
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // shared stimulus tasks
  // ---------------------------------------------------------------------------

  // register write, mirrored into the shadow thresholds (16-bit registers keep
  // only the low half of the data)
  task automatic write_reg(input cfg_idx_e idx, input logic [CFG_DATA_W-1:0] data);
    @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_wdata_i <= data;
    @(negedge clk_i);
    cfg_we_i    <= 1'b0;
    case (idx)
      CFG_OVER_WARN:    thresholds.over_warn    = data[VOLT_W-1:0];
      CFG_OVER_FAULT:   thresholds.over_fault   = data[VOLT_W-1:0];
      CFG_OVER_MARGIN:  thresholds.over_margin  = data[VOLT_W-1:0];
      CFG_OVER_DELAY:   thresholds.over_delay   = data[TIME_W-1:0];
      CFG_UNDER_WARN:   thresholds.under_warn   = data[VOLT_W-1:0];
      CFG_UNDER_FAULT:  thresholds.under_fault  = data[VOLT_W-1:0];
      CFG_UNDER_MARGIN: thresholds.under_margin = data[VOLT_W-1:0];
      CFG_UNDER_DELAY:  thresholds.under_delay  = data[TIME_W-1:0];
      default: ;
    endcase
  endtask

  // 16-bit level with junk in the upper half of the data bus
  task automatic write_level(input cfg_idx_e idx, input int level);
    logic [31:0] junk;
    junk = $urandom();
    write_reg(idx, {junk[31:16], 16'(level)});
  endtask

  // offers one sample and returns right after its transfer, valid still high;
  // the next send or a drain decides at the following falling edge
  task automatic send_sample(input logic [MOD_W-1:0] m, input logic [CELL_W-1:0] c,
                             input logic [VOLT_W-1:0] v, input logic [TIME_W-1:0] now);
    int unsigned gap;
    gap = src_idle ? $urandom_range(0, 16) : 0;
    @(negedge clk_i);
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid_i     <= 1'b1;
    module_index_i <= m;
    cell_index_i   <= c;
    cell_voltage_i <= v;
    now_ms_i       <= now;
    do @(posedge clk_i); while (!in_ready_o);
    pending_verdicts.push_back(judge_sample(m, c, v, now));
  endtask

  // stop offering, wait for every pending result, then let the pipe run dry
  task automatic drain();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (pending_verdicts.size() != 0) @(posedge clk_i);
    repeat (DRAIN_WAIT) @(posedge clk_i);
  endtask

  // voltage near one of the interesting bounds of the current thresholds
  function automatic logic [VOLT_W-1:0] near_bound();
    int ofl;
    int ufl;
    int v;
    ofl = int'(thresholds.over_fault);
    ufl = int'(thresholds.under_fault);
    case ($urandom_range(0, 7))
      0:       v = ofl - 2 + int'($urandom_range(0, 4));
      1:       v = ofl - int'(thresholds.over_margin) - 2 + int'($urandom_range(0, 4));
      2:       v = ofl + int'($urandom_range(0, 500));
      3:       v = ufl - 2 + int'($urandom_range(0, 4));
      4:       v = ufl + int'(thresholds.under_margin) - 2 + int'($urandom_range(0, 4));
      5:       v = ufl - int'($urandom_range(0, 500));
      6:       v = $urandom_range(0, 1) ? 65535 : 0;
      default: v = $urandom_range(0, 65535);
    endcase
    if (v < 0) v = 0;
    else if (v > 65535) v = 65535;
    return 16'(v);
  endfunction

  // ---------------------------------------------------------------------------
  // test tasks
  // ---------------------------------------------------------------------------

  // reset thresholds, index extremes, zero timestamp and a wrapping start time
  task automatic check_reset_levels();
    send_sample(3'd0, 4'd0, 16'd0, 32'd0);               // under timer stays idle at time 0
    send_sample(3'd0, 4'd0, 16'd0, 32'd5);               // timer starts now
    send_sample(3'd0, 4'd0, 16'd0, 32'd6);               // under fault latches, line up
    send_sample(3'd7, 4'd15, 16'hFFFF, 32'hFFFF_FFFF);
    send_sample(3'd7, 4'd15, 16'hFFFF, 32'd3);           // elapsed wraps, over latches
    send_sample(3'd0, 4'd0, 16'd1, 32'd7);               // under clears, line held
    send_sample(3'd7, 4'd15, 16'hFFFE, 32'd8);           // last fault clears, line drops
  endtask

  // delay not yet exceeded, latch, persisting condition, band between bounds, release
  task automatic check_latch_and_release();
    drain();
    write_level(CFG_OVER_WARN, 4000);
    write_level(CFG_OVER_FAULT, 4200);
    write_level(CFG_OVER_MARGIN, 100);
    write_reg(CFG_OVER_DELAY, 32'd10);
    write_level(CFG_UNDER_WARN, 3000);
    write_level(CFG_UNDER_FAULT, 2800);
    write_level(CFG_UNDER_MARGIN, 150);
    write_reg(CFG_UNDER_DELAY, 32'd20);
    send_sample(3'd3, 4'd9, 16'd4100, 32'd100);
    send_sample(3'd3, 4'd9, 16'd4200, 32'd100);
    send_sample(3'd3, 4'd9, 16'd4300, 32'd110);          // elapsed equals delay, no latch
    send_sample(3'd3, 4'd9, 16'd4250, 32'd111);
    send_sample(3'd3, 4'd9, 16'd4400, 32'd200);          // already latched
    send_sample(3'd3, 4'd9, 16'd4150, 32'd210);          // inside the band, latch holds
    send_sample(3'd3, 4'd9, 16'd4100, 32'd220);
    send_sample(3'd3, 4'd9, 16'd4099, 32'd230);
    send_sample(3'd5, 4'd2, 16'd2800, 32'd50);
    send_sample(3'd5, 4'd2, 16'd2700, 32'd71);
    send_sample(3'd5, 4'd2, 16'd2950, 32'd80);           // on the release bound, holds
    send_sample(3'd5, 4'd2, 16'd2951, 32'd90);
  endtask

  // margins that push the release bounds out of range: faults never clear
  task automatic check_release_margins();
    drain();
    write_level(CFG_OVER_WARN, 100);
    write_level(CFG_OVER_FAULT, 100);
    write_level(CFG_OVER_MARGIN, 65535);
    write_reg(CFG_OVER_DELAY, 32'd0);
    write_level(CFG_UNDER_WARN, 65000);
    write_level(CFG_UNDER_FAULT, 65000);
    write_level(CFG_UNDER_MARGIN, 65535);
    write_reg(CFG_UNDER_DELAY, 32'd0);
    send_sample(3'd2, 4'd4, 16'd100, 32'd1000);
    send_sample(3'd2, 4'd4, 16'd150, 32'd1001);
    send_sample(3'd2, 4'd4, 16'd0, 32'd1002);
    send_sample(3'd2, 4'd4, 16'hFFFF, 32'd1004);
  endtask

  // elapsed time taken modulo 2^32 against the largest useful delay
  task automatic check_clock_wrap();
    drain();
    write_level(CFG_OVER_FAULT, 40000);
    write_level(CFG_OVER_MARGIN, 0);
    write_reg(CFG_OVER_DELAY, 32'hFFFF_FFFE);
    write_level(CFG_UNDER_FAULT, 0);
    send_sample(3'd1, 4'd1, 16'd40000, 32'd1);
    send_sample(3'd1, 4'd1, 16'd50000, 32'hFFFF_FFFF);
    send_sample(3'd1, 4'd1, 16'd40000, 32'd0);           // nonzero start, time zero still counts
    send_sample(3'd1, 4'd1, 16'd39999, 32'd5);
  endtask

  // both faults of every cell latched, then all released one by one
  task automatic check_all_cells_faulted();
    int order[N_SLOTS];
    int j;
    int tmp;
    drain();
    src_idle  = $urandom_range(0, 1);
    sink_idle = $urandom_range(0, 1);
    write_level(CFG_OVER_FAULT, 0);
    write_level(CFG_UNDER_FAULT, 65535);
    write_reg(CFG_OVER_DELAY, 32'd0);
    write_reg(CFG_UNDER_DELAY, 32'd0);
    for (int s = 0; s < N_SLOTS; s++) order[s] = s;
    for (int pass = 0; pass < 2; pass++) begin
      for (int s = N_SLOTS - 1; s > 0; s--) begin
        j        = $urandom_range(0, s);
        tmp      = order[s];
        order[s] = order[j];
        order[j] = tmp;
      end
      for (int s = 0; s < N_SLOTS; s++) begin
        if (pass == 0) begin
          clock_ms = clock_ms + 2;
          if (clock_ms == '0) clock_ms = 1;
          send_sample(3'(order[s] / N_CELLS), 4'(order[s] % N_CELLS),
                      16'($urandom()), clock_ms);
          send_sample(3'(order[s] / N_CELLS), 4'(order[s] % N_CELLS),
                      16'($urandom()), clock_ms + 1);
        end else begin
          // line must stay up until the very last cell clears
          send_sample(3'(order[s] / N_CELLS), 4'(order[s] % N_CELLS),
                      16'($urandom_range(1, 65534)), clock_ms);
        end
      end
      if (pass == 0) begin
        drain();
        write_level(CFG_OVER_FAULT, 65535);
        write_level(CFG_OVER_MARGIN, 0);
        write_level(CFG_UNDER_FAULT, 0);
        write_level(CFG_UNDER_MARGIN, 0);
      end
    end
  endtask

  // long result stall while samples keep coming: block fills and stalls its input
  task automatic check_output_stall();
    drain();
    src_idle     = 1'b0;
    sink_idle    = 1'b0;
    hold_request = 400;
    for (int i = 0; i < 30; i++) begin
      clock_ms = clock_ms + 3;
      send_sample(3'($urandom()), 4'($urandom()), near_bound(), clock_ms);
    end
  endtask

  // several threshold settings, extremes first; mostly timed sequences on a
  // few hot cells, the rest fully random samples
  task automatic check_random_mix();
    logic [MOD_W-1:0]  hot_m[4];
    logic [CELL_W-1:0] hot_c[4];
    int                ofl;
    int                ufl;
    int                k;
    logic [TIME_W-1:0] stamp;
    for (int p = 0; p < RAND_PHASES; p++) begin
      drain();
      if (p < 2) begin
        // all registers at zero, then all at their maximum
        for (int r = 0; r < 8; r++) write_reg(cfg_idx_e'(r), (p == 0) ? '0 : '1);
      end else begin
        ofl = $urandom_range(30000, 60000);
        ufl = $urandom_range(1000, 25000);
        write_level(CFG_OVER_WARN, ofl - 300 + int'($urandom_range(0, 600)));
        write_level(CFG_OVER_FAULT, ofl);
        write_level(CFG_OVER_MARGIN, ($urandom_range(0, 3) == 0) ? 65535
                                                                 : $urandom_range(0, 2000));
        write_reg(CFG_OVER_DELAY, $urandom_range(0, 40));
        write_level(CFG_UNDER_WARN, ufl - 300 + int'($urandom_range(0, 600)));
        write_level(CFG_UNDER_FAULT, ufl);
        write_level(CFG_UNDER_MARGIN, ($urandom_range(0, 3) == 0) ? 65535
                                                                  : $urandom_range(0, 2000));
        write_reg(CFG_UNDER_DELAY, $urandom_range(0, 40));
      end
      if (p == 2) clock_ms = 32'hFFFF_FF00;  // run this phase across the wrap
      for (int h = 0; h < 4; h++) begin
        hot_m[h] = 3'($urandom());
        hot_c[h] = 4'($urandom());
      end
      for (int i = 0; i < PHASE_ITEMS; i++) begin
        if (i % 20 == 0) begin
          src_idle  = ($urandom_range(0, 3) != 0);
          sink_idle = ($urandom_range(0, 3) != 0);
        end
        if ($urandom_range(0, 9) < 8) begin
          k        = $urandom_range(0, 3);
          clock_ms = clock_ms + $urandom_range(0, 15);
          stamp    = ($urandom_range(0, 29) == 0) ? '0 : clock_ms;
          send_sample(hot_m[k], hot_c[k], near_bound(), stamp);
        end else begin
          send_sample(3'($urandom()), 4'($urandom()), 16'($urandom()), $urandom());
        end
      end
    end
  endtask

  // ---------------------------------------------------------------------------
  // sequence
  // ---------------------------------------------------------------------------
  initial begin
    rst_ni         = 1'b0;
    cfg_we_i       = 1'b0;
    cfg_index_i    = CFG_OVER_WARN;
    cfg_wdata_i    = '0;
    in_valid_i     = 1'b0;
    module_index_i = '0;
    cell_index_i   = '0;
    cell_voltage_i = '0;
    now_ms_i       = '0;
    src_idle       = 1'b1;
    sink_idle      = 1'b1;
    hold_request   = 0;
    mismatches     = 0;
    clock_ms       = 32'd5000;
    clear_shadow();
    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    check_reset_levels();
    check_latch_and_release();
    check_release_margins();
    check_clock_wrap();
    check_all_cells_faulted();
    check_output_stall();
    check_random_mix();
    drain();

    if (mismatches == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
